[src/encoder_rate_moving_average_assert.svh]
// assertion macros shared by the encoder rate moving average rtl
`ifndef ENCODER_RATE_MOVING_AVERAGE_ASSERT_SVH
`define ENCODER_RATE_MOVING_AVERAGE_ASSERT_SVH

// condition that must hold at every clock edge out of reset
`define ERA_ASSERT(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("era invariant violated");

// same-cycle implication
`define ERA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("era implication violated");

// next-cycle implication
`define ERA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("era sequence violated");

`endif

[src/era_pkg.sv]
// shared types and constants for the encoder rate moving average
`timescale 1ns / 1ps
package era_pkg;

  // sample and result width
  localparam int SAMPLE_W = 16;

  // saturation limits for the negated sample
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_UPDATE = 5'b00010,
    ST_ABS    = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_DONE   = 5'b10000
  } era_state_e;

endpackage

[src/era_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module era_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/encoder_rate_moving_average.sv]
// top level of the encoder rate moving average filter
`timescale 1ns / 1ps
// Each request carries one signed encoder rate sample. The sample is negated
// (the most negative code saturates to the most positive), written into a
// window of the last WINDOW values, and the mean of the values held comes out
// truncated toward zero. After reset the window holds one zero entry, so the
// divisor starts at one and grows to WINDOW. A request goes through the update,
// magnitude, divide and done states before the next request is accepted; the
// shared restoring divider produces one quotient bit per cycle over MAG_W =
// 16 + clog2(WINDOW) bits, the magnitude width of the running sum. The result
// sits in an output register, so a new sample is taken while it waits. The
// window lives in a ram; no clearing pass is needed after reset.
module encoder_rate_moving_average #(
  parameter int WINDOW = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [era_pkg::SAMPLE_W-1:0] rate_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [era_pkg::SAMPLE_W-1:0] average_rate_o
);

  import era_pkg::*;

  localparam int IDX_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW) + 1;
  localparam int MAG_W  = SUM_W - 1;
  localparam int STEP_W = $clog2(MAG_W);

  era_state_e state_q, state_d;

  logic signed [SAMPLE_W-1:0] sample_q, sample_d;
  logic signed [SUM_W-1:0]    total_q, total_d;
  logic [CNT_W-1:0]           held_q, held_d;
  logic [IDX_W-1:0]           oldest_q, oldest_d;
  logic                       seed_q, seed_d;
  logic [MAG_W-1:0]           dvd_q, dvd_d;
  logic [CNT_W-1:0]           rem_q, rem_d;
  logic [STEP_W-1:0]          step_q, step_d;
  logic                       neg_q, neg_d;
  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] avg_q, avg_d;

  logic                       in_accept;
  logic                       full;
  logic signed [SAMPLE_W-1:0] neg_sample;
  logic signed [SAMPLE_W-1:0] old_val;
  logic [SAMPLE_W-1:0]        rd_data;
  logic                       ram_we;
  logic [IDX_W-1:0]           wr_slot;
  logic [SUM_W-1:0]           mag;
  logic [CNT_W:0]             trial;
  logic [CNT_W:0]             diff;
  logic                       qbit;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign average_rate_o = avg_q;

  // negate with saturation of the most negative code
  assign neg_sample = (rate_sample_i == SAMPLE_MIN) ? SAMPLE_MAX : -rate_sample_i;

  // window bookkeeping
  assign full    = (held_q == CNT_W'(WINDOW));
  assign old_val = (full && !seed_q) ? $signed(rd_data) : '0;
  assign wr_slot = full ? oldest_q : held_q[IDX_W-1:0];
  assign ram_we  = (state_q == ST_UPDATE);

  era_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(WINDOW)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_slot),
    .wdata_i(sample_q),
    .re_i   (in_accept),
    .raddr_i(oldest_q),
    .rdata_o(rd_data)
  );

  // shared divider datapath: one restoring step per cycle
  assign mag   = total_q[SUM_W-1] ? -total_q : total_q;
  assign trial = {rem_q, dvd_q[MAG_W-1]};
  assign diff  = trial - {1'b0, held_q};
  assign qbit  = !diff[CNT_W];

  // sequencer
  always_comb begin
    state_d     = state_q;
    sample_d    = sample_q;
    total_d     = total_q;
    held_d      = held_q;
    oldest_d    = oldest_q;
    seed_d      = seed_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    step_d      = step_q;
    neg_d       = neg_q;
    avg_d       = avg_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          sample_d = neg_sample;
          state_d  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        total_d = total_q
                - {{(SUM_W-SAMPLE_W){old_val[SAMPLE_W-1]}}, old_val}
                + {{(SUM_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
        if (full) begin
          seed_d   = 1'b0;
          oldest_d = (oldest_q == IDX_W'(WINDOW - 1)) ? '0 : oldest_q + 1'b1;
        end else begin
          held_d = held_q + 1'b1;
        end
        state_d = ST_ABS;
      end
      ST_ABS: begin
        dvd_d   = mag[MAG_W-1:0];
        neg_d   = total_q[SUM_W-1];
        rem_d   = '0;
        step_d  = STEP_W'(MAG_W - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        dvd_d = {dvd_q[MAG_W-2:0], qbit};
        if (step_q == '0) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          avg_d       = neg_q ? -$signed(dvd_q[SAMPLE_W-1:0]) : $signed(dvd_q[SAMPLE_W-1:0]);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      held_q      <= CNT_W'(1);
      oldest_q    <= '0;
      seed_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      held_q      <= held_d;
      oldest_q    <= oldest_d;
      seed_q      <= seed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
    step_q   <= step_d;
    neg_q    <= neg_d;
    avg_q    <= avg_d;
  end

  `include "encoder_rate_moving_average_assert.svh"

  // fill count stays within one and the window size
  `ERA_ASSERT(a_held_range, (held_q != '0) && (held_q <= CNT_W'(WINDOW)))
  // oldest slot only moves once the window is full
  `ERA_ASSERT_IMP(a_oldest_fill, !full, oldest_q == '0)
  // the initial zero entry is only retired after the window fills
  `ERA_ASSERT_IMP(a_seed_fill, !seed_q, full)
  // an accepted request goes straight to the update step
  `ERA_ASSERT_NEXT(a_accept_update, in_accept, state_q == ST_UPDATE)
  // divider remainder stays below the divisor
  `ERA_ASSERT_IMP(a_rem_bound, state_q == ST_DIV, rem_q < held_q)

endmodule
